// ----- src/yrd_pkg.sv -----
// Shared constants, types and functions of the YOLO region decoder.
`default_nettype none
package yrd_pkg;

    localparam int LOGIT_W     = 16;
    localparam int MAG_W       = 16;
    localparam int EXP_W       = 33;
    localparam int SIG_W       = 16;
    localparam int CELL_W      = 10;
    localparam int ANC_IDX_W   = 2;
    localparam int CLASS_W     = 8;
    localparam int ANCHOR_W    = 32;
    localparam int HALF_W      = 16;
    localparam int THR_W       = 16;
    localparam int GRID_REG_W  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_QW      = 17;
    localparam int DIV_NW      = 49;
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 88;
    localparam int QUEUE_DEPTH = 4;

    localparam int NUM_ANCHORS_DEF = 3;
    localparam int MAX_GRID_DEF    = 1024;
    localparam int MAX_CLASSES_DEF = 256;

    localparam logic [THR_W-1:0]      THR_RESET  = 16'h8000;
    localparam logic [GRID_REG_W-1:0] GRID_RESET = 11'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD   = 3'd0,
        REG_GRID_WIDTH  = 3'd1,
        REG_GRID_HEIGHT = 3'd2,
        REG_ANCHOR0     = 3'd3,
        REG_ANCHOR1     = 3'd4,
        REG_ANCHOR2     = 3'd5
    } cfg_reg_t;

    // one kept record on its way from classification to box decode
    typedef struct packed {
        logic [CELL_W-1:0]   col;
        logic [CELL_W-1:0]   row;
        logic [SIG_W-1:0]    sig_x;
        logic [SIG_W-1:0]    sig_y;
        logic [EXP_W-1:0]    e_w;
        logic [EXP_W-1:0]    e_h;
        logic                w_pos;
        logic                h_pos;
        logic [ANCHOR_W-1:0] anchor;
        logic [SIG_W-1:0]    conf;
        logic [CLASS_W-1:0]  cls;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // e^(-2^i/256) in Q0.32, squared and rounded once per bit position
    function automatic logic [31:0] exp_step_c(input int i);
        logic [63:0] c;
        c = 64'd4278222805;
        for (int k = 0; k < MAG_W - 1; k++)
        begin
            if (k < i)
            begin
                c = (c * c + 64'h8000_0000) >> 32;
            end
        end
        return c[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/yrd_exp.sv -----
// Pipelined e^(-a/256) unit: one rounded constant product per magnitude bit.
`default_nettype none
module yrd_exp #(
    parameter int LANES = 6,
    parameter int SW    = 1
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         adv,
    input  wire                                         in_valid,
    input  wire  [LANES-1:0][yrd_pkg::MAG_W-1:0]        in_mag,
    input  wire  [SW-1:0]                               in_side,
    output logic                                        out_valid,
    output logic [LANES-1:0][yrd_pkg::EXP_W-1:0]        out_e,
    output logic [SW-1:0]                               out_side
);
    import yrd_pkg::*;

    localparam int NS = MAG_W;

    logic                         v_reg    [NS];
    logic [LANES-1:0][EXP_W-1:0]  acc_reg  [NS];
    logic [SW-1:0]                side_reg [NS];
    logic [LANES-1:0][MAG_W-1:0]  mag_reg  [NS-1];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam logic [31:0] CS = exp_step_c(s);
        logic                        v_prev;
        logic [LANES-1:0][EXP_W-1:0] acc_prev;
        logic [LANES-1:0][MAG_W-1:0] mag_prev;
        logic [SW-1:0]               side_prev;
        logic [LANES-1:0][EXP_W-1:0] acc_n;

        if (s == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign mag_prev  = in_mag;
            assign side_prev = in_side;
            for (genvar l = 0; l < LANES; l++)
            begin : g_one
                assign acc_prev[l] = {1'b1, {(EXP_W-1){1'b0}}};
            end
        end
        else
        begin : g_next
            assign v_prev    = v_reg[s-1];
            assign mag_prev  = mag_reg[s-1];
            assign side_prev = side_reg[s-1];
            assign acc_prev  = acc_reg[s-1];
        end

        always_comb
        begin
            logic [2*EXP_W-2:0] prod;
            for (int l = 0; l < LANES; l++)
            begin
                prod = (2*EXP_W-1)'(acc_prev[l]) * (2*EXP_W-1)'(CS)
                     + (2*EXP_W-1)'(33'h0_8000_0000);
                acc_n[l] = mag_prev[l][s] ? prod[2*EXP_W-2:32] : acc_prev[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                acc_reg[s]  <= acc_n;
                side_reg[s] <= side_prev;
            end
        end

        if (s < NS - 1)
        begin : g_mag
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    mag_reg[s] <= mag_prev;
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_e     = acc_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule
`default_nettype wire

// ----- src/yrd_div.sv -----
// Pipelined restoring divider: one quotient bit per stage over several lanes.
`default_nettype none
module yrd_div #(
    parameter int LANES = 4,
    parameter int NW    = 49,
    parameter int DW    = 33,
    parameter int QW    = 17,
    parameter int SW    = 1
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        adv,
    input  wire                        in_valid,
    input  wire  [LANES-1:0][NW-1:0]   in_num,
    input  wire  [LANES-1:0][DW-1:0]   in_den,
    input  wire  [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [LANES-1:0][QW-1:0]   out_q,
    output logic [SW-1:0]              out_side
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic                       v_reg    [QW];
    logic [LANES-1:0][QW-1:0]   q_reg    [QW];
    logic [SW-1:0]              side_reg [QW];
    logic [LANES-1:0][NW-1:0]   rem_reg  [QW-1];
    logic [LANES-1:0][DW-1:0]   den_reg  [QW-1];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int J = QW - 1 - s;
        logic                      v_prev;
        logic [LANES-1:0][NW-1:0]  rem_prev;
        logic [LANES-1:0][DW-1:0]  den_prev;
        logic [LANES-1:0][QW-1:0]  q_prev;
        logic [SW-1:0]             side_prev;
        logic [LANES-1:0][NW-1:0]  rem_n;
        logic [LANES-1:0][QW-1:0]  q_n;

        if (s == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = in_num;
            assign den_prev  = in_den;
            assign q_prev    = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign den_prev  = den_reg[s-1];
            assign q_prev    = q_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_comb
        begin
            logic [CW-1:0] rem_c;
            logic [CW-1:0] dsh;
            logic          ge;
            for (int l = 0; l < LANES; l++)
            begin
                rem_c    = CW'(rem_prev[l]);
                dsh      = CW'(den_prev[l]) << J;
                ge       = (rem_c >= dsh);
                rem_n[l] = ge ? NW'(rem_c - dsh) : rem_prev[l];
                q_n[l]   = q_prev[l] | (ge ? (QW'(1) << J) : QW'(0));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[s]    <= q_n;
                side_reg[s] <= side_prev;
            end
        end

        if (s < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[s] <= rem_n;
                    den_reg[s] <= den_prev;
                end
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

// ----- src/yrd_front.sv -----
// Front part: accept records, compute sigmoids and exponents, keep or drop.
`default_nettype none
module yrd_front #(
    parameter int NUM_ANCHORS = yrd_pkg::NUM_ANCHORS_DEF,
    parameter int MAX_CLASSES = yrd_pkg::MAX_CLASSES_DEF
) (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  wire  [yrd_pkg::THR_W-1:0]                     threshold,
    input  wire  [NUM_ANCHORS-1:0][yrd_pkg::ANCHOR_W-1:0] anchors,
    input  wire                                           s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  wire  [yrd_pkg::IN_DATA_W-1:0]                 s_axis_tdata,
    input  wire  yrd_pkg::q_stat_t                        q_stat,
    output logic                                          push,
    output yrd_pkg::item_t                                push_item
);
    import yrd_pkg::*;

    localparam int LANES = 6;   // objectness, class, x, y, width, height
    localparam int SLN   = 4;   // lanes that need a sigmoid

    typedef struct packed {
        logic [CELL_W-1:0]   col;
        logic [CELL_W-1:0]   row;
        logic [CLASS_W-1:0]  cls;
        logic [ANCHOR_W-1:0] anchor;
        logic                in_range;
        logic [SLN-1:0]      neg;
        logic                w_pos;
        logic                h_pos;
    } side_t;

    typedef struct packed {
        side_t               side;
        logic [EXP_W-1:0]    e_w;
        logic [EXP_W-1:0]    e_h;
    } dside_t;

    logic adv;
    assign adv           = !q_stat.full;
    assign s_axis_tready = adv;

    // input unpack
    logic [CELL_W-1:0]              in_col;
    logic [CELL_W-1:0]              in_row;
    logic [ANC_IDX_W-1:0]           in_anc;
    logic [CLASS_W-1:0]             in_cls;
    logic [LANES-1:0][LOGIT_W-1:0]  in_logit;
    side_t                          f0_side_c;
    logic [LANES-1:0][MAG_W-1:0]    f0_mag_c;

    assign in_col      = s_axis_tdata[9:0];
    assign in_row      = s_axis_tdata[19:10];
    assign in_anc      = s_axis_tdata[21:20];
    assign in_logit[2] = s_axis_tdata[37:22];
    assign in_logit[3] = s_axis_tdata[53:38];
    assign in_logit[4] = s_axis_tdata[69:54];
    assign in_logit[5] = s_axis_tdata[85:70];
    assign in_logit[0] = s_axis_tdata[101:86];
    assign in_cls      = s_axis_tdata[109:102];
    assign in_logit[1] = s_axis_tdata[125:110];

    always_comb
    begin
        logic [ANCHOR_W-1:0] asel;
        asel = '0;
        for (int k = 0; k < NUM_ANCHORS; k++)
        begin
            if (32'(in_anc) == 32'(k))
            begin
                asel = anchors[k];
            end
        end
        for (int l = 0; l < LANES; l++)
        begin
            f0_mag_c[l] = in_logit[l][LOGIT_W-1] ? MAG_W'(-in_logit[l]) : in_logit[l];
        end
        f0_side_c.col      = in_col;
        f0_side_c.row      = in_row;
        f0_side_c.cls      = in_cls;
        f0_side_c.anchor   = asel;
        f0_side_c.in_range = (32'(in_anc) < 32'(NUM_ANCHORS))
                          && (32'(in_cls) < 32'(MAX_CLASSES));
        for (int l = 0; l < SLN; l++)
        begin
            f0_side_c.neg[l] = in_logit[l][LOGIT_W-1];
        end
        f0_side_c.w_pos = !in_logit[4][LOGIT_W-1] && (in_logit[4] != '0);
        f0_side_c.h_pos = !in_logit[5][LOGIT_W-1] && (in_logit[5] != '0);
    end

    logic                        f0_valid_reg;
    side_t                       f0_side_reg;
    logic [LANES-1:0][MAG_W-1:0] f0_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f0_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_side_reg <= f0_side_c;
            f0_mag_reg  <= f0_mag_c;
        end
    end

    logic                        e_valid;
    logic [LANES-1:0][EXP_W-1:0] e_val;
    logic [$bits(side_t)-1:0]    e_side;

    yrd_exp #(
        .LANES (LANES),
        .SW    ($bits(side_t))
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f0_valid_reg),
        .in_mag    (f0_mag_reg),
        .in_side   (f0_side_reg),
        .out_valid (e_valid),
        .out_e     (e_val),
        .out_side  (e_side)
    );

    // sigmoid = round(e * 2^16 / (2^32 + e))
    logic                          p_valid_reg;
    dside_t                        p_dside_reg;
    logic [SLN-1:0][DIV_NW-1:0]    p_num_reg;
    logic [SLN-1:0][EXP_W:0]       p_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= e_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [EXP_W:0] den;
        if (adv)
        begin
            for (int l = 0; l < SLN; l++)
            begin
                den          = {2'b01, {(EXP_W-1){1'b0}}} + (EXP_W+1)'(e_val[l]);
                p_den_reg[l] <= den;
                p_num_reg[l] <= (DIV_NW'(e_val[l]) << 16) + DIV_NW'(den >> 1);
            end
            p_dside_reg.side <= side_t'(e_side);
            p_dside_reg.e_w  <= e_val[4];
            p_dside_reg.e_h  <= e_val[5];
        end
    end

    logic                         d_valid;
    logic [SLN-1:0][DIV_QW-1:0]   d_q;
    logic [$bits(dside_t)-1:0]    d_side;

    yrd_div #(
        .LANES (SLN),
        .NW    (DIV_NW),
        .DW    (EXP_W + 1),
        .QW    (DIV_QW),
        .SW    ($bits(dside_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid_reg),
        .in_num    (p_num_reg),
        .in_den    (p_den_reg),
        .in_side   (p_dside_reg),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_side  (d_side)
    );

    logic                       g_valid_reg;
    dside_t                     g_dside_reg;
    logic [SLN-1:0][SIG_W-1:0]  g_sig_reg;
    dside_t                     d_dside;

    assign d_dside = dside_t'(d_side);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g_valid_reg <= d_valid;
        end
    end

    // negative logit takes s, else 1 - s capped below one
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < SLN; l++)
            begin
                if (d_dside.side.neg[l])
                begin
                    g_sig_reg[l] <= d_q[l][SIG_W-1:0];
                end
                else if (d_q[l] == '0)
                begin
                    g_sig_reg[l] <= '1;
                end
                else
                begin
                    g_sig_reg[l] <= SIG_W'(17'h1_0000 - d_q[l]);
                end
            end
            g_dside_reg <= d_dside;
        end
    end

    logic [2*SIG_W-1:0] conf_full;
    logic [SIG_W-1:0]   conf;
    logic               keep;

    assign conf_full = (2*SIG_W)'(g_sig_reg[1]) * (2*SIG_W)'(g_sig_reg[0]);
    assign conf      = conf_full[2*SIG_W-1:SIG_W];
    assign keep      = g_dside_reg.side.in_range
                    && (g_sig_reg[0] >= threshold)
                    && (conf >= threshold);
    assign push      = g_valid_reg && keep && adv;

    always_comb
    begin
        push_item.col    = g_dside_reg.side.col;
        push_item.row    = g_dside_reg.side.row;
        push_item.sig_x  = g_sig_reg[2];
        push_item.sig_y  = g_sig_reg[3];
        push_item.e_w    = g_dside_reg.e_w;
        push_item.e_h    = g_dside_reg.e_h;
        push_item.w_pos  = g_dside_reg.side.w_pos;
        push_item.h_pos  = g_dside_reg.side.h_pos;
        push_item.anchor = g_dside_reg.side.anchor;
        push_item.conf   = conf;
        push_item.cls    = g_dside_reg.side.cls;
    end

endmodule
`default_nettype wire

// ----- src/yrd_queue.sv -----
// Short register queue between the classifying front and the decoding back.
`default_nettype none
module yrd_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire  yrd_pkg::item_t push_item,
    input  wire                pop,
    output yrd_pkg::item_t     pop_item,
    output yrd_pkg::q_stat_t   q_stat
);
    import yrd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_item     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ----- src/yrd_back.sv -----
// Back part: decode box centers and sizes of kept records, hold the result.
`default_nettype none
module yrd_back #(
    parameter int MAX_GRID = yrd_pkg::MAX_GRID_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  [yrd_pkg::GRID_REG_W-1:0]    grid_width,
    input  wire  [yrd_pkg::GRID_REG_W-1:0]    grid_height,
    input  wire  yrd_pkg::q_stat_t            q_stat,
    input  wire  yrd_pkg::item_t              q_item,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [yrd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import yrd_pkg::*;

    localparam int LN   = 4;   // center x, center y, width, height
    localparam int GW   = $clog2(MAX_GRID + 1);
    localparam int GCW  = (GW > GRID_REG_W) ? GW : GRID_REG_W;
    localparam int CMPW = EXP_W + DIV_QW;
    localparam int PRW  = HALF_W + EXP_W + 1;

    typedef struct packed {
        logic [LN-1:0]     sat;
        logic              w_pos;
        logic              h_pos;
        logic              anz_w;
        logic              anz_h;
        logic [HALF_W-1:0] prod_w;
        logic [HALF_W-1:0] prod_h;
        logic [SIG_W-1:0]  conf;
        logic [CLASS_W-1:0] cls;
    } bside_t;

    function automatic logic [GW-1:0] grid_eff(input logic [GRID_REG_W-1:0] g);
        logic [GCW-1:0] gx;
        gx = GCW'(g);
        if (gx == '0)
        begin
            return GW'(1);
        end
        if (gx > GCW'(MAX_GRID))
        begin
            return GW'(MAX_GRID);
        end
        return GW'(gx);
    endfunction

    function automatic logic [HALF_W-1:0] clip16(input logic [DIV_QW-1:0] q);
        return q[DIV_QW-1] ? '1 : q[HALF_W-1:0];
    endfunction

    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || m_axis_tready;
    assign pop = adv && !q_stat.empty;

    logic  b0_valid_reg;
    item_t b0_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b0_valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_item_reg <= q_item;
        end
    end

    // divider operands; an overflowing quotient skips the divide
    logic [LN-1:0][DIV_NW-1:0] num_c;
    logic [LN-1:0][EXP_W-1:0]  den_c;
    logic [HALF_W-1:0]         anc_w;
    logic [HALF_W-1:0]         anc_h;
    logic [PRW-1:0]            prod_w_c;
    logic [PRW-1:0]            prod_h_c;
    logic [GW-1:0]             eff_w;
    logic [GW-1:0]             eff_h;

    assign anc_w = b0_item_reg.anchor[ANCHOR_W-1:HALF_W];
    assign anc_h = b0_item_reg.anchor[HALF_W-1:0];
    assign eff_w = grid_eff(grid_width);
    assign eff_h = grid_eff(grid_height);

    always_comb
    begin
        num_c[0] = DIV_NW'(b0_item_reg.sig_x) + (DIV_NW'(b0_item_reg.col) << 16)
                 + DIV_NW'(eff_w >> 1);
        den_c[0] = EXP_W'(eff_w);
        num_c[1] = DIV_NW'(b0_item_reg.sig_y) + (DIV_NW'(b0_item_reg.row) << 16)
                 + DIV_NW'(eff_h >> 1);
        den_c[1] = EXP_W'(eff_h);
        num_c[2] = (DIV_NW'(anc_w) << 32) + DIV_NW'(b0_item_reg.e_w >> 1);
        den_c[2] = b0_item_reg.e_w;
        num_c[3] = (DIV_NW'(anc_h) << 32) + DIV_NW'(b0_item_reg.e_h >> 1);
        den_c[3] = b0_item_reg.e_h;
        prod_w_c = PRW'(anc_w) * PRW'(b0_item_reg.e_w) + PRW'(33'h0_8000_0000);
        prod_h_c = PRW'(anc_h) * PRW'(b0_item_reg.e_h) + PRW'(33'h0_8000_0000);
    end

    logic                      b1_valid_reg;
    logic [LN-1:0][DIV_NW-1:0] b1_num_reg;
    logic [LN-1:0][EXP_W-1:0]  b1_den_reg;
    bside_t                    b1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg <= b0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic sat;
        if (adv)
        begin
            for (int l = 0; l < LN; l++)
            begin
                sat               = CMPW'(num_c[l]) >= (CMPW'(den_c[l]) << DIV_QW);
                b1_side_reg.sat[l] <= sat;
                b1_num_reg[l]     <= sat ? '0 : num_c[l];
                b1_den_reg[l]     <= sat ? EXP_W'(1) : den_c[l];
            end
            b1_side_reg.w_pos  <= b0_item_reg.w_pos;
            b1_side_reg.h_pos  <= b0_item_reg.h_pos;
            b1_side_reg.anz_w  <= (anc_w != '0);
            b1_side_reg.anz_h  <= (anc_h != '0);
            b1_side_reg.prod_w <= prod_w_c[HALF_W+31:32];
            b1_side_reg.prod_h <= prod_h_c[HALF_W+31:32];
            b1_side_reg.conf   <= b0_item_reg.conf;
            b1_side_reg.cls    <= b0_item_reg.cls;
        end
    end

    logic                      d_valid;
    logic [LN-1:0][DIV_QW-1:0] d_q;
    logic [$bits(bside_t)-1:0] d_side_v;
    bside_t                    d_side;

    yrd_div #(
        .LANES (LN),
        .NW    (DIV_NW),
        .DW    (EXP_W),
        .QW    (DIV_QW),
        .SW    ($bits(bside_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b1_valid_reg),
        .in_num    (b1_num_reg),
        .in_den    (b1_den_reg),
        .in_side   (b1_side_reg),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_side  (d_side_v)
    );

    assign d_side = bside_t'(d_side_v);

    logic [HALF_W-1:0] cx_c;
    logic [HALF_W-1:0] cy_c;
    logic [HALF_W-1:0] bw_c;
    logic [HALF_W-1:0] bh_c;

    always_comb
    begin
        cx_c = d_side.sat[0] ? '1 : clip16(d_q[0]);
        cy_c = d_side.sat[1] ? '1 : clip16(d_q[1]);
        if (!d_side.w_pos)
        begin
            bw_c = d_side.prod_w;
        end
        else if (d_side.sat[2])
        begin
            bw_c = d_side.anz_w ? '1 : '0;
        end
        else
        begin
            bw_c = clip16(d_q[2]);
        end
        if (!d_side.h_pos)
        begin
            bh_c = d_side.prod_h;
        end
        else if (d_side.sat[3])
        begin
            bh_c = d_side.anz_h ? '1 : '0;
        end
        else
        begin
            bh_c = clip16(d_q[3]);
        end
    end

    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {d_side.cls, d_side.conf, bh_c, bw_c, cy_c, cx_c};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- src/yolo_region_decode.sv -----
// Top level of the YOLO output-layer region decoder.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata, one logit record
//  m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata, one detection
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One record is accepted every cycle while the queue is not full; the front pipeline
// (16 exponent stages and a 17-stage sigmoid divider) feeds the queue and the back
// pipeline (17-stage box divider) feeds the output register.
// Reset loads the register defaults and empties both pipelines and the queue.
// The front stalls only while the 4-entry queue is full; the back stalls on m_axis_tready.
`default_nettype none
module yolo_region_decode #(
    parameter int NUM_ANCHORS = yrd_pkg::NUM_ANCHORS_DEF,
    parameter int MAX_GRID    = yrd_pkg::MAX_GRID_DEF,
    parameter int MAX_CLASSES = yrd_pkg::MAX_CLASSES_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // cell_column[9:0] cell_row[19:10] anchor_index[21:20] raw_x[37:22]
    // raw_y[53:38] raw_width[69:54] raw_height[85:70] raw_objectness[101:86]
    // class_id[109:102] raw_class[125:110], zero above
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire  [yrd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // center_x[15:0] center_y[31:16] box_width[47:32] box_height[63:48]
    // confidence[79:64] class_out[87:80]
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    output logic [yrd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [yrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [yrd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import yrd_pkg::*;

    logic [THR_W-1:0]                     thr_reg;
    logic [GRID_REG_W-1:0]                grid_w_reg;
    logic [GRID_REG_W-1:0]                grid_h_reg;
    logic [NUM_ANCHORS-1:0][ANCHOR_W-1:0] anchor_reg;

    assign cfg_ready = 1'b1;

    // drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            grid_w_reg <= GRID_RESET;
            grid_h_reg <= GRID_RESET;
            anchor_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_THRESHOLD)
            begin
                thr_reg <= cfg_data[THR_W-1:0];
            end
            if (cfg_index == REG_GRID_WIDTH)
            begin
                grid_w_reg <= cfg_data[GRID_REG_W-1:0];
            end
            if (cfg_index == REG_GRID_HEIGHT)
            begin
                grid_h_reg <= cfg_data[GRID_REG_W-1:0];
            end
            for (int k = 0; k < NUM_ANCHORS; k++)
            begin
                if (32'(cfg_index) == 32'(REG_ANCHOR0) + 32'(k))
                begin
                    anchor_reg[k] <= cfg_data[ANCHOR_W-1:0];
                end
            end
        end
    end

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    item_t   push_item;
    item_t   pop_item;

    yrd_front #(
        .NUM_ANCHORS (NUM_ANCHORS),
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .threshold     (thr_reg),
        .anchors       (anchor_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    yrd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    yrd_back #(
        .MAX_GRID (MAX_GRID)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .grid_width    (grid_w_reg),
        .grid_height   (grid_h_reg),
        .q_stat        (q_stat),
        .q_item        (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the YOLO region decoder: directed table, then randomized phases.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import yrd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [15:0]        conf;
        logic [15:0]        bh;
        logic [15:0]        bw;
        logic [15:0]        cy;
        logic [15:0]        cx;
    } det_t;

    typedef struct {
        logic [IN_DATA_W-1:0] rec;
        bit                   typed;
        bit                   has_det;
        det_t                 det;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register shadow
    logic [15:0] thr_q;
    logic [10:0] gw_q;
    logic [10:0] gh_q;
    logic [31:0] anc_q [3];

    det_t     det_q [$];
    int       fails;
    bit       idle_on;
    bit       hold_req;
    int       stall_cnt;
    dir_row_t dir_tbl [$];

    yolo_region_decode u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // e^(-a/256) in Q0.32
    function automatic logic [127:0] exp_q32(input logic [15:0] a);
        logic [127:0] acc;
        logic [127:0] c;
        acc = 128'h1_0000_0000;
        c   = 128'd4278222805;
        for (int i = 0; i < 16; i++)
        begin
            if (a[i])
                acc = (acc * c + 128'h8000_0000) >> 32;
            c = (c * c + 128'h8000_0000) >> 32;
        end
        return acc;
    endfunction

    function automatic logic [15:0] sigmoid_q16(input logic signed [15:0] x);
        logic [15:0]  mag;
        logic [127:0] e;
        logic [127:0] den;
        logic [127:0] s;
        mag = x[15] ? 16'(-x) : x;
        e   = exp_q32(mag);
        den = 128'h1_0000_0000 + e;
        s   = ((e << 16) + den / 2) / den;
        if (x[15])
            return s[15:0];
        s = 128'd65536 - s;
        return (s > 128'd65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [15:0] box_size(input logic [15:0] anc,
                                             input logic signed [15:0] t);
        logic [127:0] a;
        logic [127:0] e;
        logic [127:0] r;
        a = anc;
        if (t[15] || t == 0)
        begin
            e = exp_q32(16'(-t));
            r = (a * e + 128'h8000_0000) >> 32;
            return r[15:0];
        end
        e = exp_q32(t);
        if (e == 0)
            return (anc != 0) ? 16'hFFFF : 16'h0;
        r = ((a << 32) + e / 2) / e;
        return (r > 128'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [15:0] box_center(input logic signed [15:0] t,
                                               input logic [9:0] cell_idx,
                                               input logic [10:0] grid);
        logic [127:0] g;
        logic [127:0] r;
        g = (grid == 0) ? 128'd1 : (grid > 11'd1024) ? 128'd1024 : 128'(grid);
        r = (128'(sigmoid_q16(t)) + (128'(cell_idx) << 16) + g / 2) / g;
        return (r > 128'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    // decode one record against the shadow registers; 0 when it is dropped
    function automatic bit decode_record(input logic [IN_DATA_W-1:0] d, output det_t r);
        logic [1:0]  anc;
        logic [15:0] obj;
        logic [31:0] conf;
        logic [31:0] anchor;
        r   = '0;
        anc = d[21:20];
        if (anc > 2'd2)
            return 0;
        obj = sigmoid_q16(d[101:86]);
        if (obj < thr_q)
            return 0;
        conf = (32'(sigmoid_q16(d[125:110])) * 32'(obj)) >> 16;
        if (conf < 32'(thr_q))
            return 0;
        anchor = anc_q[anc];
        r.cx   = box_center(d[37:22], d[9:0], gw_q);
        r.cy   = box_center(d[53:38], d[19:10], gh_q);
        r.bw   = box_size(anchor[31:16], d[69:54]);
        r.bh   = box_size(anchor[15:0], d[85:70]);
        r.conf = conf[15:0];
        r.cls  = d[109:102];
        return 1;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_rec(
        input logic [9:0] col, input logic [9:0] row, input logic [1:0] anc,
        input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
        input logic [15:0] h, input logic [15:0] obj, input logic [7:0] cid,
        input logic [15:0] cls);
        return {2'b00, cls, cid, obj, h, w, y, x, anc, row, col};
    endfunction

    function automatic logic [15:0] rand_logit(input int full_odds, input int lo, input int hi);
        if ($urandom_range(0, 3) < full_odds)
            return 16'($urandom);
        return 16'($urandom_range(0, hi - lo) + lo);
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_rec();
        return pack_rec(10'($urandom), 10'($urandom), 2'($urandom_range(0, 3)),
                        rand_logit(2, -1024, 1024), rand_logit(2, -1024, 1024),
                        rand_logit(1, -2048, 1024), rand_logit(1, -2048, 1024),
                        rand_logit(1, -512, 3072), 8'($urandom),
                        rand_logit(1, -512, 3072));
    endfunction

    task automatic send_rec(input logic [IN_DATA_W-1:0] d, input bit typed,
                            input bit has_det, input det_t td);
        int   gap;
        det_t p;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (typed)
        begin
            if (has_det)
                det_q.insert(det_q.size(), td);
        end
        else if (decode_record(d, p))
        begin
            det_q.insert(det_q.size(), p);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_THRESHOLD:   thr_q    = val[15:0];
            REG_GRID_WIDTH:  gw_q     = val[10:0];
            REG_GRID_HEIGHT: gh_q     = val[10:0];
            REG_ANCHOR0:     anc_q[0] = val;
            REG_ANCHOR1:     anc_q[1] = val;
            REG_ANCHOR2:     anc_q[2] = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drain everything, including records that give no detection
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (det_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    // detection checker
    always @(posedge clk)
    begin
        det_t got;
        det_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (det_q.size() == 0)
            begin
                $error("unexpected detection %h", m_axis_tdata);
                fails++;
            end
            else
            begin
                want = det_q.pop_front();
                if (got.cx != want.cx)
                begin
                    $error("center_x: expected %0d, got %0d", want.cx, got.cx);
                    fails++;
                end
                if (got.cy != want.cy)
                begin
                    $error("center_y: expected %0d, got %0d", want.cy, got.cy);
                    fails++;
                end
                if (got.bw != want.bw)
                begin
                    $error("box_width: expected %0d, got %0d", want.bw, got.bw);
                    fails++;
                end
                if (got.bh != want.bh)
                begin
                    $error("box_height: expected %0d, got %0d", want.bh, got.bh);
                    fails++;
                end
                if (got.conf != want.conf)
                begin
                    $error("confidence: expected %0d, got %0d", want.conf, got.conf);
                    fails++;
                end
                if (got.cls != want.cls)
                begin
                    $error("class_out: expected %0d, got %0d", want.cls, got.cls);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        dir_row_t row;
        int       n;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fails         = 0;
        stall_cnt     = 0;
        idle_on       = 1;
        hold_req      = 0;
        thr_q         = THR_RESET;
        gw_q          = GRID_RESET;
        gh_q          = GRID_RESET;
        anc_q         = '{32'h0, 32'h0, 32'h0};

        // typed rows run on reset registers with anchor 0 still zero
        row = '{pack_rec(0, 0, 0, 16'h8000, 16'h8000, 0, 0, 16'h7FFF, 7, 16'h7FFF),
                1, 1, '{cls: 7, conf: 65534, bh: 0, bw: 0, cy: 0, cx: 0}};
        dir_tbl.insert(dir_tbl.size(), row);
        // objectness at minimum: dropped
        row = '{pack_rec(5, 5, 0, 0, 0, 0, 0, 16'h8000, 1, 16'h7FFF), 1, 0, '0};
        dir_tbl.insert(dir_tbl.size(), row);
        // anchor index out of range: dropped
        row = '{pack_rec(1, 1, 3, 0, 0, 0, 0, 16'h7FFF, 2, 16'h7FFF), 1, 0, '0};
        dir_tbl.insert(dir_tbl.size(), row);
        dir_tbl.insert(dir_tbl.size(),
                       '{pack_rec(1023, 1023, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  16'h7FFF, 255, 16'h7FFF), 0, 0, '0});
        dir_tbl.insert(dir_tbl.size(),
                       '{pack_rec(12, 12, 2, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                                  16'h7FFF, 0, 16'h7FFF), 0, 0, '0});
        dir_tbl.insert(dir_tbl.size(),
                       '{pack_rec(6, 3, 1, 0, 0, 0, 0, 0, 9, 16'h7FFF), 0, 0, '0});
        dir_tbl.insert(dir_tbl.size(),
                       '{pack_rec(13, 14, 2, 256, -256, 512, -512, 1024, 100, 1024),
                         0, 0, '0});
        dir_tbl.insert(dir_tbl.size(),
                       '{pack_rec(0, 1023, 1, -1, 1, 1, -1, 16'h7FFF, 200, 16'h8000),
                         0, 0, '0});
        dir_tbl.insert(dir_tbl.size(),
                       '{pack_rec(400, 0, 2, 2048, 16'hFFFF, 4000, 16'hF000, 300, 50, 300),
                         0, 0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_ANCHOR1, 32'h1000_1000);
        write_reg(REG_ANCHOR2, 32'hFFFF_0001);
        foreach (dir_tbl[i])
            send_rec(dir_tbl[i].rec, dir_tbl[i].typed, dir_tbl[i].has_det, dir_tbl[i].det);
        settle();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: write_reg(REG_THRESHOLD, 32'h0);
                1: write_reg(REG_THRESHOLD, 32'hFFFF);
                2: write_reg(REG_THRESHOLD, 32'h4000);
                default: write_reg(REG_THRESHOLD, $urandom_range(0, 40000));
            endcase
            case (p)
                0: begin write_reg(REG_GRID_WIDTH, 1);    write_reg(REG_GRID_HEIGHT, 1024); end
                1: begin write_reg(REG_GRID_WIDTH, 0);    write_reg(REG_GRID_HEIGHT, 2047); end
                2: begin write_reg(REG_GRID_WIDTH, 2047); write_reg(REG_GRID_HEIGHT, 0);    end
                3: begin write_reg(REG_GRID_WIDTH, 1024); write_reg(REG_GRID_HEIGHT, 1);    end
                default:
                begin
                    write_reg(REG_GRID_WIDTH, $urandom_range(1, 1024));
                    write_reg(REG_GRID_HEIGHT, $urandom_range(1, 2047));
                end
            endcase
            write_reg(REG_ANCHOR0, (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0 : $urandom);
            write_reg(REG_ANCHOR1, (p == 0) ? 32'hFFFF_FFFF : $urandom);
            write_reg(REG_ANCHOR2, (p == 1) ? 32'h0 : $urandom);
            if (p == 4)
                write_reg(REG_UNUSED, $urandom);
            idle_on = (p != 2);
            if (p == 3)
                hold_req = 1;
            n = (p == 1) ? 40 : 95;
            for (int k = 0; k < n; k++)
                send_rec(rand_rec(), 0, 0, '0);
            settle();
        end

        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
